[hw/rtl/i2cm_pkg.sv]
`default_nettype none

package i2cm_pkg;

  // width of the quarter-phase tick divider
  localparam int TICK_COUNTER_WIDTH = 16;

  // configuration register widths and reset values
  localparam int QUARTER_PERIOD_W = 16;
  localparam int ACK_WAIT_LIMIT_W = 4;
  localparam int CFG_DATA_W       = 16;
  localparam int CFG_INDEX_W      = 1;
  localparam logic [QUARTER_PERIOD_W-1:0] QUARTER_PERIOD_RESET = 16'd250;
  localparam logic [ACK_WAIT_LIMIT_W-1:0] ACK_WAIT_LIMIT_RESET = 4'd10;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_QUARTER_PERIOD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_WAIT_LIMIT = 1'b1;

  // command codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_ADDR_NACK  = 2'd1;
  localparam logic [1:0] ERR_INDEX_NACK = 2'd2;
  localparam logic [1:0] ERR_LATE_NACK  = 2'd3;

  // stream payload widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  // live configuration
  typedef struct packed {
    logic [QUARTER_PERIOD_W-1:0] quarter_period;
    logic [ACK_WAIT_LIMIT_W-1:0] ack_wait_limit;
  } cfg_t;

  // one input tick
  typedef struct packed {
    logic       sda_in;
    logic [7:0] write_data;
    logic [7:0] reg_index;
    logic [6:0] device_addr;
    logic [1:0] action;
  } item_t;

  // one result, lowest field last so it packs into the low bits
  typedef struct packed {
    logic [1:0] error_code;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_release;
    logic       scl_release;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/i2c_master_register_access.sv]
`default_nettype none

// I2C master for single-byte register reads and writes over open-drain SCL/SDA.
// Every input transaction is one system tick and yields exactly one registered
// result transaction, showing the line levels, status, last read byte and error
// code after that tick. A write runs START, address+W, index, data, STOP; a read
// runs START, address+W, index, repeated START, address+R, one byte NACKed,
// STOP. A missing ACK ends the transaction with an error code and a STOP. One
// tick is taken per clock cycle while the skid entry is empty: the whole bus
// state update is one registered pass, and a two-deep output buffer keeps the
// input side ready while one result waits.
// s_axis_tdata, low bit up: action[1:0], device_addr[8:2], reg_index[16:9],
// write_data[24:17], sda_in[25], zeros above.
// m_axis_tdata, low bit up: scl_release[0], sda_release[1], busy_res[2],
// done_res[3], read_data[11:4], error_code[13:12], zeros above.
// Registers: index 0 quarter_period (ticks per quarter bit, reset 250),
// index 1 ack_wait_limit (extra polls of the ACK quarter, reset 10).
module i2c_master_register_access (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // action, device_addr, reg_index, write_data, sda_in
  input  wire logic [i2cm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // scl_release, sda_release, busy_res, done_res, read_data, error_code
  output logic [i2cm_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  input  wire logic                                 cfg_we,
  input  wire logic [i2cm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int ItemW = $bits(i2cm_pkg::item_t);
  localparam int ResW  = $bits(i2cm_pkg::res_t);

  i2cm_pkg::cfg_t  cfg;
  i2cm_pkg::item_t item;
  i2cm_pkg::res_t  res, out_res, skid_res;
  logic            accept, out_free, skid_valid;

  assign item          = i2cm_pkg::item_t'(s_axis_tdata[ItemW-1:0]);
  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {{(i2cm_pkg::OUT_TDATA_W - ResW){1'b0}}, out_res};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quarter_period <= i2cm_pkg::QUARTER_PERIOD_RESET;
      cfg.ack_wait_limit <= i2cm_pkg::ACK_WAIT_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cm_pkg::REG_QUARTER_PERIOD: cfg.quarter_period <= cfg_data;
        i2cm_pkg::REG_ACK_WAIT_LIMIT:
          cfg.ack_wait_limit <= cfg_data[i2cm_pkg::ACK_WAIT_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  i2cm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .res    (res)
  );

  // output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (!out_free && accept) begin
      skid_res <= res;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/i2cm_core.sv]
`default_nettype none

module i2cm_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire i2cm_pkg::item_t item,
  input  wire i2cm_pkg::cfg_t  cfg,
  output i2cm_pkg::res_t       res
);

  localparam int TickW = i2cm_pkg::TICK_COUNTER_WIDTH;
  localparam int LimW  = ((TickW > i2cm_pkg::QUARTER_PERIOD_W) ?
                          TickW : i2cm_pkg::QUARTER_PERIOD_W) + 1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_ADDR, PH_ADDR_ACK, PH_INDEX, PH_INDEX_ACK,
    PH_RSTART, PH_RADDR, PH_RADDR_ACK, PH_DATA, PH_DATA_ACK, PH_RECV,
    PH_MNACK, PH_STOP
  } phase_t;

  phase_t             phase, phase_next;
  logic [1:0]         quarter, quarter_next;
  logic [TickW-1:0]   tick_count, tick_count_next;
  logic [2:0]         bit_count, bit_count_next;
  logic [7:0]         shift_byte, shift_byte_next;
  logic [3:0]         ack_wait_count, ack_wait_count_next;
  logic               cmd_read, cmd_read_next;
  logic [6:0]         cmd_addr, cmd_addr_next;
  logic [7:0]         cmd_index, cmd_index_next;
  logic [7:0]         cmd_data, cmd_data_next;
  logic [7:0]         read_byte, read_byte_next;
  logic [1:0]         error_latch, error_latch_next;
  logic               done_next;

  logic [LimW-1:0]    qp_ext, cap, limit, tick_inc;
  logic               tick_end;
  logic [7:0]         recv_shift;
  logic               inner;

  // quarter length: zero counts as one, clipped to the counter range
  always_comb begin
    qp_ext   = LimW'(cfg.quarter_period);
    cap      = LimW'(1) << TickW;
    if (cfg.quarter_period == '0) begin
      limit = LimW'(1);
    end else if (qp_ext > cap) begin
      limit = cap;
    end else begin
      limit = qp_ext;
    end
    tick_inc = LimW'(tick_count) + LimW'(1);
    tick_end = (tick_inc >= limit);
  end

  assign recv_shift = (quarter == 2'd1) ? {shift_byte[6:0], item.sda_in} : shift_byte;

  // next bus state for this tick
  always_comb begin
    phase_next          = phase;
    quarter_next        = quarter;
    tick_count_next     = tick_count;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    ack_wait_count_next = ack_wait_count;
    cmd_read_next       = cmd_read;
    cmd_addr_next       = cmd_addr;
    cmd_index_next      = cmd_index;
    cmd_data_next       = cmd_data;
    read_byte_next      = read_byte;
    error_latch_next    = error_latch;
    done_next           = 1'b0;

    if (phase == PH_IDLE) begin
      if (item.action == i2cm_pkg::ACT_WRITE || item.action == i2cm_pkg::ACT_READ) begin
        cmd_read_next       = (item.action == i2cm_pkg::ACT_READ);
        cmd_addr_next       = item.device_addr;
        cmd_index_next      = item.reg_index;
        cmd_data_next       = item.write_data;
        phase_next          = PH_START;
        quarter_next        = 2'd0;
        tick_count_next     = '0;
        bit_count_next      = 3'd0;
        ack_wait_count_next = 4'd0;
        error_latch_next    = i2cm_pkg::ERR_NONE;
        if (item.action == i2cm_pkg::ACT_READ) begin
          read_byte_next = 8'd0;
        end
      end
    end else if (!tick_end) begin
      tick_count_next = tick_count + TickW'(1);
    end else begin
      tick_count_next = '0;
      unique case (phase)
        PH_START, PH_RSTART: begin
          if (quarter != 2'd3) begin
            quarter_next = quarter + 2'd1;
          end else begin
            quarter_next   = 2'd0;
            bit_count_next = 3'd0;
            if (phase == PH_START) begin
              phase_next      = PH_ADDR;
              shift_byte_next = {cmd_addr, 1'b0};
            end else begin
              phase_next      = PH_RADDR;
              shift_byte_next = {cmd_addr, 1'b1};
            end
          end
        end
        PH_ADDR, PH_INDEX, PH_RADDR, PH_DATA: begin
          if (quarter != 2'd3) begin
            quarter_next = quarter + 2'd1;
          end else begin
            quarter_next    = 2'd0;
            shift_byte_next = {shift_byte[6:0], 1'b0};
            if (bit_count == 3'd7) begin
              bit_count_next      = 3'd0;
              ack_wait_count_next = 4'd0;
              unique case (phase)
                PH_ADDR:  phase_next = PH_ADDR_ACK;
                PH_INDEX: phase_next = PH_INDEX_ACK;
                PH_RADDR: phase_next = PH_RADDR_ACK;
                default:  phase_next = PH_DATA_ACK;
              endcase
            end else begin
              bit_count_next = bit_count + 3'd1;
            end
          end
        end
        PH_ADDR_ACK, PH_INDEX_ACK, PH_RADDR_ACK, PH_DATA_ACK: begin
          if (quarter == 2'd2) begin
            // poll the acknowledge, stretching this quarter while sda is high
            if (!item.sda_in) begin
              quarter_next = 2'd3;
            end else if (ack_wait_count < cfg.ack_wait_limit) begin
              ack_wait_count_next = ack_wait_count + 4'd1;
            end else begin
              unique case (phase)
                PH_ADDR_ACK:  error_latch_next = i2cm_pkg::ERR_ADDR_NACK;
                PH_INDEX_ACK: error_latch_next = i2cm_pkg::ERR_INDEX_NACK;
                default:      error_latch_next = i2cm_pkg::ERR_LATE_NACK;
              endcase
              quarter_next = 2'd3;
            end
          end else if (quarter != 2'd3) begin
            quarter_next = quarter + 2'd1;
          end else begin
            quarter_next = 2'd0;
            if (error_latch != i2cm_pkg::ERR_NONE) begin
              phase_next = PH_STOP;
            end else begin
              unique case (phase)
                PH_ADDR_ACK: begin
                  phase_next      = PH_INDEX;
                  shift_byte_next = cmd_index;
                  bit_count_next  = 3'd0;
                end
                PH_INDEX_ACK: begin
                  if (cmd_read) begin
                    phase_next = PH_RSTART;
                  end else begin
                    phase_next      = PH_DATA;
                    shift_byte_next = cmd_data;
                    bit_count_next  = 3'd0;
                  end
                end
                PH_RADDR_ACK: begin
                  phase_next      = PH_RECV;
                  shift_byte_next = 8'd0;
                  bit_count_next  = 3'd0;
                end
                default: phase_next = PH_STOP;
              endcase
            end
          end
        end
        PH_RECV: begin
          shift_byte_next = recv_shift;
          if (quarter != 2'd3) begin
            quarter_next = quarter + 2'd1;
          end else begin
            quarter_next = 2'd0;
            if (bit_count == 3'd7) begin
              bit_count_next = 3'd0;
              read_byte_next = recv_shift;
              phase_next     = PH_MNACK;
            end else begin
              bit_count_next = bit_count + 3'd1;
            end
          end
        end
        PH_MNACK: begin
          if (quarter != 2'd3) begin
            quarter_next = quarter + 2'd1;
          end else begin
            quarter_next = 2'd0;
            phase_next   = PH_STOP;
          end
        end
        PH_STOP: begin
          if (quarter != 2'd3) begin
            quarter_next = quarter + 2'd1;
          end else begin
            quarter_next = 2'd0;
            phase_next   = PH_IDLE;
            done_next    = 1'b1;
          end
        end
        default: begin
          phase_next   = PH_IDLE;
          quarter_next = 2'd0;
        end
      endcase
    end
  end

  // line levels and status for the state after this tick
  always_comb begin
    inner           = (quarter_next == 2'd1) || (quarter_next == 2'd2);
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = done_next;
    res.read_data   = read_byte_next;
    res.error_code  = error_latch_next;
    unique case (phase_next)
      PH_START: begin
        res.scl_release = (quarter_next != 2'd3);
        res.sda_release = (quarter_next < 2'd2);
      end
      PH_RSTART: begin
        res.scl_release = inner;
        res.sda_release = (quarter_next < 2'd2);
      end
      PH_ADDR, PH_INDEX, PH_RADDR, PH_DATA: begin
        res.scl_release = inner;
        res.sda_release = shift_byte_next[7];
      end
      PH_ADDR_ACK, PH_INDEX_ACK, PH_RADDR_ACK, PH_DATA_ACK, PH_RECV, PH_MNACK: begin
        res.scl_release = inner;
        res.sda_release = 1'b1;
      end
      PH_STOP: begin
        res.scl_release = (quarter_next != 2'd0);
        res.sda_release = (quarter_next >= 2'd2);
      end
      default: begin
        res.scl_release = 1'b1;
        res.sda_release = 1'b1;
      end
    endcase
  end

  // bus state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      quarter        <= 2'd0;
      tick_count     <= '0;
      bit_count      <= 3'd0;
      shift_byte     <= 8'd0;
      ack_wait_count <= 4'd0;
      cmd_read       <= 1'b0;
      cmd_addr       <= 7'd0;
      cmd_index      <= 8'd0;
      cmd_data       <= 8'd0;
      read_byte      <= 8'd0;
      error_latch    <= i2cm_pkg::ERR_NONE;
    end else if (accept) begin
      phase          <= phase_next;
      quarter        <= quarter_next;
      tick_count     <= tick_count_next;
      bit_count      <= bit_count_next;
      shift_byte     <= shift_byte_next;
      ack_wait_count <= ack_wait_count_next;
      cmd_read       <= cmd_read_next;
      cmd_addr       <= cmd_addr_next;
      cmd_index      <= cmd_index_next;
      cmd_data       <= cmd_data_next;
      read_byte      <= read_byte_next;
      error_latch    <= error_latch_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/i2cm_checker.sv]
`default_nettype none

module i2cm_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 s_axis_tvalid,
  input wire logic                                 s_axis_tready,
  input wire logic                                 m_axis_tvalid,
  input wire logic                                 m_axis_tready,
  input wire logic [i2cm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // reset empties the output buffer and opens the input
  assert property (@(posedge clk) rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("buffer not empty after reset");

  // every accepted tick leaves a result pending
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  // an idle bus has both lines released
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[0] && m_axis_tdata[1])
    else $error("line driven while idle");

  // a done pulse comes with busy dropped
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
    else $error("done while busy");

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[sim/i2c_master_register_access_tb.sv]
module i2c_master_register_access_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // command code outside the defined set, handled as a plain tick
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // cycles without any transaction before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 5000;
  // minimum random items per configuration phase, more until the bus is idle
  localparam int PHASE_ITEMS = 60;
  // results seen before the receiver holds off for a long stretch
  localparam int LONG_HOLD_AT = 300;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_START     = 5'd1,
    PH_ADDR      = 5'd2,
    PH_ADDR_ACK  = 5'd3,
    PH_INDEX     = 5'd4,
    PH_INDEX_ACK = 5'd5,
    PH_RSTART    = 5'd6,
    PH_RADDR     = 5'd7,
    PH_RADDR_ACK = 5'd8,
    PH_DATA      = 5'd9,
    PH_DATA_ACK  = 5'd10,
    PH_RECV      = 5'd11,
    PH_MNACK     = 5'd12,
    PH_STOP      = 5'd13
  } phase_e;

  // one directed bus transaction and the slave behavior around it
  typedef struct packed {
    logic [1:0]  act;
    logic [6:0]  addr;
    logic [7:0]  idx;
    logic [7:0]  wdat;
    logic [15:0] qp;
    logic [3:0]  awl;
    phase_e      nack_at;
    logic [6:0]  late;
    logic [7:0]  sbyte;
    logic        pin_err;
    logic [1:0]  err;
    logic        pin_rd;
    logic [7:0]  rd;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [i2cm_pkg::IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [i2cm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_we;
  logic [i2cm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data;

  always #5 clk = ~clk;

  i2c_master_register_access DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // bus master mirror state
  logic [15:0] cur_qp;
  logic [3:0]  cur_awl;
  phase_e      bus_ph;
  logic [1:0]  qtr;
  logic [15:0] tick_cnt;
  logic [2:0]  bit_cnt;
  logic [7:0]  tx_shift;
  logic [3:0]  wait_cnt;
  logic        cmd_rd;
  logic [6:0]  cmd_addr;
  logic [7:0]  cmd_idx;
  logic [7:0]  cmd_wdat;
  logic [7:0]  rx_byte;
  logic [1:0]  err_code;

  // emulated slave for the current bus transaction
  phase_e     sl_nack_at;
  logic [6:0] sl_late_pct;
  logic [7:0] sl_byte;
  logic       sl_noisy;

  // fixed values that override the mirror on the closing status word, or on the whole word of an idle tick
  logic       pin_on;
  logic       pin_idle;
  logic       pin_rd_on;
  logic [1:0] pin_err;
  logic [7:0] pin_rd;

  i2cm_pkg::res_t pending_status [$];
  int fails = 0;
  int results_seen = 0;
  int items_sent = 0;
  int unsigned quiet = 0;
  logic calm = 1'b0;
  logic gappy = 1'b0;

  row_t plan [9] = '{
    '{i2cm_pkg::ACT_TICK,  7'h00, 8'h00, 8'h00, 16'd250, 4'd10, PH_IDLE,      7'd0, 8'h00,
      1'b1, i2cm_pkg::ERR_NONE,       1'b1, 8'h00},
    '{ACT_UNUSED,          7'h7f, 8'hff, 8'hff, 16'd250, 4'd10, PH_IDLE,      7'd0, 8'h00,
      1'b1, i2cm_pkg::ERR_NONE,       1'b1, 8'h00},
    '{i2cm_pkg::ACT_WRITE, 7'h7f, 8'h00, 8'hff, 16'd2,   4'd0,  PH_ADDR_ACK,  7'd0, 8'h00,
      1'b1, i2cm_pkg::ERR_ADDR_NACK,  1'b0, 8'h00},
    '{i2cm_pkg::ACT_TICK,  7'h00, 8'h00, 8'h00, 16'd2,   4'd0,  PH_IDLE,      7'd0, 8'h00,
      1'b1, i2cm_pkg::ERR_ADDR_NACK,  1'b1, 8'h00},
    '{i2cm_pkg::ACT_READ,  7'h00, 8'h00, 8'hff, 16'd0,   4'd15, PH_IDLE,      7'd0, 8'hff,
      1'b1, i2cm_pkg::ERR_NONE,       1'b1, 8'hff},
    '{i2cm_pkg::ACT_WRITE, 7'h2a, 8'h5a, 8'ha5, 16'd1,   4'd15, PH_INDEX_ACK, 7'd0, 8'h00,
      1'b1, i2cm_pkg::ERR_INDEX_NACK, 1'b0, 8'h00},
    '{i2cm_pkg::ACT_WRITE, 7'h55, 8'ha5, 8'h5a, 16'd1,   4'd3,  PH_DATA_ACK,  7'd0, 8'h00,
      1'b1, i2cm_pkg::ERR_LATE_NACK,  1'b0, 8'h00},
    '{i2cm_pkg::ACT_READ,  7'h33, 8'hcc, 8'h0f, 16'd1,   4'd0,  PH_RADDR_ACK, 7'd0, 8'h96,
      1'b1, i2cm_pkg::ERR_LATE_NACK,  1'b1, 8'h00},
    '{i2cm_pkg::ACT_TICK,  7'h00, 8'h00, 8'h00, 16'd1,   4'd0,  PH_IDLE,      7'd0, 8'h00,
      1'b1, i2cm_pkg::ERR_LATE_NACK,  1'b1, 8'h00}
  };

  // one system tick of the bus master, returns the status word after it
  function automatic i2cm_pkg::res_t advance_bus(input i2cm_pkg::item_t it);
    i2cm_pkg::res_t r;
    logic [16:0] lim;
    logic done;
    logic inner;
    done = 1'b0;
    if (bus_ph == PH_IDLE) begin
      if (it.action == i2cm_pkg::ACT_WRITE || it.action == i2cm_pkg::ACT_READ) begin
        cmd_rd = (it.action == i2cm_pkg::ACT_READ);
        cmd_addr = it.device_addr;
        cmd_idx = it.reg_index;
        cmd_wdat = it.write_data;
        bus_ph = PH_START;
        qtr = 2'd0;
        tick_cnt = 16'd0;
        bit_cnt = 3'd0;
        wait_cnt = 4'd0;
        err_code = i2cm_pkg::ERR_NONE;
        if (cmd_rd) rx_byte = 8'h00;
      end
    end else begin
      // zero period behaves as one tick per quarter
      lim = (cur_qp == 16'd0) ? 17'd1 : {1'b0, cur_qp};
      if ({1'b0, tick_cnt} + 17'd1 >= lim) begin
        tick_cnt = 16'd0;
        case (bus_ph)
          PH_START, PH_RSTART: begin
            if (qtr != 2'd3) begin
              qtr = qtr + 2'd1;
            end else begin
              tx_shift = {cmd_addr, bus_ph == PH_RSTART};
              bus_ph = (bus_ph == PH_START) ? PH_ADDR : PH_RADDR;
              bit_cnt = 3'd0;
              qtr = 2'd0;
            end
          end
          PH_ADDR, PH_INDEX, PH_RADDR, PH_DATA: begin
            if (qtr != 2'd3) begin
              qtr = qtr + 2'd1;
            end else begin
              qtr = 2'd0;
              tx_shift = tx_shift << 1;
              if (bit_cnt == 3'd7) begin
                bit_cnt = 3'd0;
                wait_cnt = 4'd0;
                bus_ph = phase_e'(bus_ph + 5'd1);
              end else begin
                bit_cnt = bit_cnt + 3'd1;
              end
            end
          end
          PH_ADDR_ACK, PH_INDEX_ACK, PH_RADDR_ACK, PH_DATA_ACK: begin
            // ack polled at the end of the third quarter, which repeats while sda is high
            if (qtr == 2'd2) begin
              if (!it.sda_in) begin
                qtr = 2'd3;
              end else if (wait_cnt < cur_awl) begin
                wait_cnt = wait_cnt + 4'd1;
              end else begin
                if (bus_ph == PH_ADDR_ACK) err_code = i2cm_pkg::ERR_ADDR_NACK;
                else if (bus_ph == PH_INDEX_ACK) err_code = i2cm_pkg::ERR_INDEX_NACK;
                else err_code = i2cm_pkg::ERR_LATE_NACK;
                qtr = 2'd3;
              end
            end else if (qtr != 2'd3) begin
              qtr = qtr + 2'd1;
            end else begin
              qtr = 2'd0;
              if (err_code != i2cm_pkg::ERR_NONE) begin
                bus_ph = PH_STOP;
              end else begin
                case (bus_ph)
                  PH_ADDR_ACK: begin
                    bus_ph = PH_INDEX;
                    tx_shift = cmd_idx;
                    bit_cnt = 3'd0;
                  end
                  PH_INDEX_ACK: begin
                    if (cmd_rd) begin
                      bus_ph = PH_RSTART;
                    end else begin
                      bus_ph = PH_DATA;
                      tx_shift = cmd_wdat;
                      bit_cnt = 3'd0;
                    end
                  end
                  PH_RADDR_ACK: begin
                    bus_ph = PH_RECV;
                    tx_shift = 8'h00;
                    bit_cnt = 3'd0;
                  end
                  default: bus_ph = PH_STOP;
                endcase
              end
            end
          end
          PH_RECV: begin
            // data bits sampled at the end of the second quarter, msb first
            if (qtr == 2'd1) tx_shift = {tx_shift[6:0], it.sda_in};
            if (qtr != 2'd3) begin
              qtr = qtr + 2'd1;
            end else begin
              qtr = 2'd0;
              if (bit_cnt == 3'd7) begin
                bit_cnt = 3'd0;
                rx_byte = tx_shift;
                bus_ph = PH_MNACK;
              end else begin
                bit_cnt = bit_cnt + 3'd1;
              end
            end
          end
          PH_MNACK: begin
            if (qtr != 2'd3) begin
              qtr = qtr + 2'd1;
            end else begin
              qtr = 2'd0;
              bus_ph = PH_STOP;
            end
          end
          PH_STOP: begin
            if (qtr != 2'd3) begin
              qtr = qtr + 2'd1;
            end else begin
              qtr = 2'd0;
              bus_ph = PH_IDLE;
              done = 1'b1;
            end
          end
          default: begin
            bus_ph = PH_IDLE;
            qtr = 2'd0;
          end
        endcase
      end else begin
        tick_cnt = tick_cnt + 16'd1;
      end
    end

    // line levels for the quarter now in force
    inner = (qtr == 2'd1 || qtr == 2'd2);
    case (bus_ph)
      PH_START: begin
        r.scl_release = (qtr != 2'd3);
        r.sda_release = (qtr < 2'd2);
      end
      PH_RSTART: begin
        r.scl_release = inner;
        r.sda_release = (qtr < 2'd2);
      end
      PH_ADDR, PH_INDEX, PH_RADDR, PH_DATA: begin
        r.scl_release = inner;
        r.sda_release = tx_shift[7];
      end
      PH_STOP: begin
        r.scl_release = (qtr != 2'd0);
        r.sda_release = (qtr >= 2'd2);
      end
      PH_IDLE: begin
        r.scl_release = 1'b1;
        r.sda_release = 1'b1;
      end
      default: begin
        r.scl_release = inner;
        r.sda_release = 1'b1;
      end
    endcase
    r.busy_res = (bus_ph != PH_IDLE);
    r.done_res = done;
    r.read_data = rx_byte;
    r.error_code = err_code;
    return r;
  endfunction

  // next tick with random command fields and sda chosen by the emulated slave unless it is noisy
  function automatic i2cm_pkg::item_t make_fill();
    i2cm_pkg::item_t it;
    it.action = 2'($urandom_range(3));
    it.device_addr = 7'($urandom);
    it.reg_index = 8'($urandom);
    it.write_data = 8'($urandom);
    it.sda_in = 1'($urandom_range(1));
    if (!sl_noisy) begin
      case (bus_ph)
        PH_ADDR_ACK, PH_INDEX_ACK, PH_RADDR_ACK, PH_DATA_ACK:
          it.sda_in = (bus_ph == sl_nack_at) || ($urandom_range(99) < sl_late_pct);
        PH_RECV: it.sda_in = sl_byte[3'd7 - bit_cnt];
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic hold_off(input int n);
    @(negedge clk) s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // offer one tick, mirror it once the transaction completes
  task automatic push_tick(input i2cm_pkg::item_t it);
    i2cm_pkg::res_t want;
    if (items_sent % 64 == 0) gappy = 1'($urandom_range(1));
    items_sent++;
    if (!calm && gappy && $urandom_range(7) == 0) hold_off($urandom_range(1, 15));
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= i2cm_pkg::IN_TDATA_W'(it);
    do @(posedge clk); while (!s_axis_tready);
    want = advance_bus(it);
    if (pin_on) begin
      if (pin_idle) begin
        want = '{error_code: pin_err, read_data: pin_rd, done_res: 1'b0, busy_res: 1'b0,
                 sda_release: 1'b1, scl_release: 1'b1};
      end else if (want.done_res) begin
        want.error_code = pin_err;
        if (pin_rd_on) want.read_data = pin_rd;
      end
    end
    pending_status.push_back(want);
  endtask

  // drain, settle, then load both registers
  task automatic set_config(input logic [15:0] qp, input logic [3:0] awl);
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= i2cm_pkg::REG_QUARTER_PERIOD;
    cfg_data <= qp;
    @(negedge clk);
    cfg_index <= i2cm_pkg::REG_ACK_WAIT_LIMIT;
    cfg_data <= {12'($urandom), awl};
    @(negedge clk) cfg_we <= 1'b0;
    cur_qp = qp;
    cur_awl = awl;
  endtask

  // result side: random stalls, one long hold-off, quiet stretches
  initial begin
    int stall;
    int seg;
    logic choppy;
    logic held;
    stall = 0;
    seg = 0;
    choppy = 1'b0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= LONG_HOLD_AT) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      if (seg == 0) begin
        seg = 64;
        choppy = 1'($urandom_range(1));
      end
      seg--;
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (choppy && !calm && $urandom_range(7) == 0) begin
        stall = $urandom_range(1, 15) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest mirrored status
  always @(posedge clk) begin
    i2cm_pkg::res_t got;
    i2cm_pkg::res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got = i2cm_pkg::res_t'(m_axis_tdata[$bits(i2cm_pkg::res_t)-1:0]);
      if (pending_status.size() == 0) begin
        $error("result with no expectation pending: %h", m_axis_tdata);
        fails++;
      end else begin
        want = pending_status.pop_front();
        if (got.scl_release !== want.scl_release) begin
          $error("scl_release: expected %0d, got %0d", want.scl_release, got.scl_release);
          fails++;
        end
        if (got.sda_release !== want.sda_release) begin
          $error("sda_release: expected %0d, got %0d", want.sda_release, got.sda_release);
          fails++;
        end
        if (got.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
          fails++;
        end
        if (got.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
          fails++;
        end
        if (got.read_data !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
          fails++;
        end
        if (got.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
          fails++;
        end
      end
    end
  end

  // hang detection
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("i2c_master_register_access test failed");
      $finish;
    end
  end

  initial begin
    row_t r;
    i2cm_pkg::item_t it;
    logic [15:0] qp;
    logic [3:0] awl;
    int count;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_qp = i2cm_pkg::QUARTER_PERIOD_RESET;
    cur_awl = i2cm_pkg::ACK_WAIT_LIMIT_RESET;
    bus_ph = PH_IDLE;
    qtr = 2'd0;
    tick_cnt = 16'd0;
    bit_cnt = 3'd0;
    tx_shift = 8'h00;
    wait_cnt = 4'd0;
    cmd_rd = 1'b0;
    cmd_addr = 7'h00;
    cmd_idx = 8'h00;
    cmd_wdat = 8'h00;
    rx_byte = 8'h00;
    err_code = i2cm_pkg::ERR_NONE;
    sl_nack_at = PH_IDLE;
    sl_late_pct = 7'd0;
    sl_byte = 8'h00;
    sl_noisy = 1'b0;
    pin_on = 1'b0;
    pin_idle = 1'b0;
    pin_rd_on = 1'b0;
    pin_err = i2cm_pkg::ERR_NONE;
    pin_rd = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed transactions, register changes only where the row asks for one
    for (int i = 0; i < $size(plan); i++) begin
      r = plan[i];
      if (r.qp != cur_qp || r.awl != cur_awl) set_config(r.qp, r.awl);
      sl_nack_at = r.nack_at;
      sl_late_pct = r.late;
      sl_byte = r.sbyte;
      sl_noisy = 1'b0;
      pin_on = r.pin_err;
      pin_rd_on = r.pin_rd;
      pin_err = r.err;
      pin_rd = r.rd;
      pin_idle = !(r.act == i2cm_pkg::ACT_WRITE || r.act == i2cm_pkg::ACT_READ);
      it = make_fill();
      it.action = r.act;
      it.device_addr = r.addr;
      it.reg_index = r.idx;
      it.write_data = r.wdat;
      push_tick(it);
      pin_idle = 1'b0;
      while (bus_ph != PH_IDLE) push_tick(make_fill());
      pin_on = 1'b0;
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < 2; ph++) begin
      case (ph)
        0: begin
          qp = 16'd1;
          awl = 4'($urandom_range(15));
        end
        default: begin
          qp = 16'd0;
          awl = 4'd15;
        end
      endcase
      set_config(qp, awl);
      if (ph == 1) calm = 1'b1;
      count = 0;
      while (count < PHASE_ITEMS || bus_ph != PH_IDLE) begin
        it = make_fill();
        if (bus_ph == PH_IDLE) begin
          if ($urandom_range(9) < 8) begin
            // fresh slave behavior for each bus transaction
            sl_noisy = ($urandom_range(99) < 15);
            case ($urandom_range(9))
              0: sl_nack_at = PH_ADDR_ACK;
              1: sl_nack_at = PH_INDEX_ACK;
              2: sl_nack_at = PH_RADDR_ACK;
              3: sl_nack_at = PH_DATA_ACK;
              default: sl_nack_at = PH_IDLE;
            endcase
            case ($urandom_range(3))
              2: sl_late_pct = 7'd25;
              3: sl_late_pct = 7'd60;
              default: sl_late_pct = 7'd0;
            endcase
            sl_byte = 8'($urandom);
            it.action = $urandom_range(1) ? i2cm_pkg::ACT_READ : i2cm_pkg::ACT_WRITE;
          end else begin
            it.action = $urandom_range(1) ? ACT_UNUSED : i2cm_pkg::ACT_TICK;
          end
        end
        push_tick(it);
        count++;
      end
    end

    // wait for the last results, then settle
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_status.size() != 0) begin
      $error("%0d expected results never arrived", pending_status.size());
      fails++;
    end
    if (fails == 0) begin
      $display("i2c_master_register_access test passed");
    end else begin
      $display("i2c_master_register_access test failed");
    end
    $finish;
  end

endmodule
